// File: hw/rtl/lmat_pkg.sv
package lmat_pkg;

  localparam int LUX_W       = 23;
  localparam int CNTR_W      = 32;
  localparam int WINDOW_DEF  = 8;
  localparam int CFG_IDX_W   = 1;
  localparam int S_TDATA_W   = 24;
  localparam int M_TDATA_W   = 112;

  localparam logic [LUX_W-1:0] HIGH_THRESHOLD_RST = LUX_W'(50000);
  localparam logic [LUX_W-1:0] LOW_THRESHOLD_RST  = LUX_W'(1000);

  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_THRESHOLD  = 1'b1;

  typedef logic [LUX_W-1:0]  lux_t;
  typedef logic [CNTR_W-1:0] cntr_t;

endpackage

// File: hw/rtl/lux_moving_average_threshold_unit.sv
// Moving average of lux samples (hundredths of a lux) over a window of
// WINDOW_SIZE entries, with high and low alarms against two programmable
// thresholds; each alarm stays set until the mean is back between them. A
// request with s_tuser low is a missed sample: it bumps the missed counter in
// its accept cycle and yields no result. A valid sample passes S_UPDATE, which
// updates the ring and running window sum, then S_DIV, where a bit-serial
// restoring divider turns the sum into the mean one quotient bit per cycle,
// then S_DONE, which loads the result once the output register is free;
// s_tready stays low meanwhile. A result waits in the output register while
// the next request is accepted.
module lux_moving_average_threshold_unit
  import lmat_pkg::*;
#(
  parameter int WINDOW_SIZE = WINDOW_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // lux_value
  input  logic                 s_tuser,   // sample_valid
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // sequence_number, raw_lux, filtered_lux, missed_count, high_alarm, low_alarm
  output logic [M_TDATA_W-1:0] m_tdata,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LUX_W-1:0]     cfg_data
);

  localparam int POS_W      = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam int CNT_W      = $clog2(WINDOW_SIZE + 1);
  localparam int SUM_W      = LUX_W + $clog2(WINDOW_SIZE);
  localparam int DIV_CNT_W  = $clog2(SUM_W);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_UPDATE = 2'd1;
  localparam logic [1:0] S_DIV    = 2'd2;
  localparam logic [1:0] S_DONE   = 2'd3;

  logic [1:0]           state;
  lux_t                 high_threshold;
  lux_t                 low_threshold;
  lux_t                 ring [WINDOW_SIZE];
  lux_t                 rd_data;
  lux_t                 lux_in;
  logic [POS_W-1:0]     write_position;
  logic [CNT_W-1:0]     fill_count;
  logic [SUM_W-1:0]     window_sum;
  logic [SUM_W-1:0]     window_sum_next;
  cntr_t                sequence_counter;
  cntr_t                missed_counter;
  logic                 high_flag;
  logic                 low_flag;
  logic                 high_flag_next;
  logic                 low_flag_next;
  logic [SUM_W-1:0]     quo;
  logic [CNT_W-1:0]     rem;
  logic [CNT_W:0]       rem_shift;
  logic                 rem_ge;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic                 full;
  logic                 in_fire;
  lux_t                 mean;
  logic                 out_free;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = s_tvalid && s_tready;
  assign full      = (fill_count == CNT_W'(WINDOW_SIZE));
  assign out_free  = !m_tvalid || m_tready;
  assign mean      = quo[LUX_W-1:0];

  assign window_sum_next = window_sum - (full ? SUM_W'(rd_data) : '0) + SUM_W'(lux_in);

  assign rem_shift = {rem, quo[SUM_W-1]};
  assign rem_ge    = (rem_shift >= {1'b0, fill_count});

  always_comb begin
    high_flag_next = high_flag;
    low_flag_next  = low_flag;
    priority if (mean > high_threshold) begin
      high_flag_next = 1'b1;
    end else if (mean < low_threshold) begin
      low_flag_next = 1'b1;
    end else begin
      high_flag_next = 1'b0;
      low_flag_next  = 1'b0;
    end
  end

  // window storage
  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_data <= ring[write_position];
    end
    if (state == S_UPDATE) begin
      ring[write_position] <= lux_in;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      lux_in <= s_tdata[LUX_W-1:0];
    end
    if (state == S_UPDATE) begin
      quo <= window_sum_next;
      rem <= '0;
    end else if (state == S_DIV) begin
      rem <= rem_ge ? CNT_W'(rem_shift - {1'b0, fill_count}) : rem_shift[CNT_W-1:0];
      quo <= {quo[SUM_W-2:0], rem_ge};
    end
    if (state == S_DONE && out_free) begin
      m_tdata <= {low_flag_next, high_flag_next, missed_counter, mean, lux_in,
                   sequence_counter};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      high_threshold   <= HIGH_THRESHOLD_RST;
      low_threshold    <= LOW_THRESHOLD_RST;
      write_position   <= '0;
      fill_count       <= '0;
      window_sum       <= '0;
      sequence_counter <= '0;
      missed_counter   <= '0;
      high_flag        <= 1'b0;
      low_flag         <= 1'b0;
      div_cnt          <= '0;
      m_tvalid         <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_HIGH_THRESHOLD: high_threshold <= cfg_data;
          CFG_LOW_THRESHOLD:  low_threshold  <= cfg_data;
          default: ;
        endcase
      end
      if (state == S_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            if (s_tuser) begin
              state <= S_UPDATE;
            end else begin
              missed_counter <= missed_counter + 1'b1;
            end
          end
        end
        S_UPDATE: begin
          window_sum <= window_sum_next;
          if (!full) begin
            fill_count <= fill_count + 1'b1;
          end
          write_position <= (write_position == POS_W'(WINDOW_SIZE - 1)) ? '0
                                                                       : write_position + 1'b1;
          div_cnt <= DIV_CNT_W'(SUM_W - 1);
          state   <= S_DIV;
        end
        S_DIV: begin
          div_cnt <= div_cnt - 1'b1;
          if (div_cnt == '0) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            high_flag        <= high_flag_next;
            low_flag         <= low_flag_next;
            sequence_counter <= sequence_counter + 1'b1;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
